// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every rising clock edge outside reset.
`define KF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define KF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/kfcv_pkg.sv -----
// Shared types, operand codes and the micro-op program of the two-state filter.
// Depends on nothing; imported by the multiply unit, the divider and the top level.
package kfcv_pkg;

  localparam int DATA_W = 32;
  localparam int RST_DIAG_UNITS = 100;

  typedef logic [4:0] src_t;

  localparam src_t SRC_ZERO = 5'd0;
  localparam src_t SRC_X0   = 5'd1;
  localparam src_t SRC_X1   = 5'd2;
  localparam src_t SRC_P00  = 5'd3;
  localparam src_t SRC_P01  = 5'd4;
  localparam src_t SRC_P10  = 5'd5;
  localparam src_t SRC_P11  = 5'd6;
  localparam src_t SRC_Y    = 5'd7;
  localparam src_t SRC_T0   = 5'd8;
  localparam src_t SRC_T1   = 5'd9;
  localparam src_t SRC_S    = 5'd10;
  localparam src_t SRC_K0   = 5'd11;
  localparam src_t SRC_K1   = 5'd12;
  localparam src_t SRC_R0   = 5'd13;
  localparam src_t SRC_R1   = 5'd14;
  localparam src_t SRC_M00  = 5'd15;
  localparam src_t SRC_M01  = 5'd16;
  localparam src_t SRC_M10  = 5'd17;
  localparam src_t SRC_M11  = 5'd18;
  localparam src_t SRC_A0   = 5'd19;
  localparam src_t SRC_A1   = 5'd20;
  localparam src_t SRC_F00  = 5'd21;
  localparam src_t SRC_F01  = 5'd22;
  localparam src_t SRC_F10  = 5'd23;
  localparam src_t SRC_F11  = 5'd24;
  localparam src_t SRC_H0   = 5'd25;
  localparam src_t SRC_H1   = 5'd26;
  localparam src_t SRC_RN   = 5'd27;
  localparam src_t SRC_Z    = 5'd28;

  typedef logic [1:0] cmode_t;
  localparam cmode_t CM_NONE = 2'd0;
  localparam cmode_t CM_ADD  = 2'd1;
  localparam cmode_t CM_SUB  = 2'd2;

  typedef logic [4:0] pc_t;
  localparam pc_t OP_S    = 5'd3;
  localparam pc_t OP_R0   = 5'd4;
  localparam pc_t OP_A0   = 5'd12;
  localparam pc_t OP_LAST = 5'd21;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_F00 = 3'd0;
  localparam cfg_idx_t REG_F01 = 3'd1;
  localparam cfg_idx_t REG_F10 = 3'd2;
  localparam cfg_idx_t REG_F11 = 3'd3;
  localparam cfg_idx_t REG_H0  = 3'd4;
  localparam cfg_idx_t REG_H1  = 3'd5;
  localparam cfg_idx_t REG_RN  = 3'd6;
  localparam cfg_idx_t REG_IV  = 3'd7;

  typedef struct packed {
    src_t   a0;
    src_t   b0;
    src_t   a1;
    src_t   b1;
    src_t   dst;
    cmode_t cmode;
    src_t   csrc;
  } op_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

  typedef struct packed {
    logic              done;
    logic              clamp;
    logic [DATA_W-1:0] quot;
  } div_res_t;

  function automatic op_t mk(src_t a0, src_t b0, src_t a1, src_t b1, src_t dst,
                             cmode_t cm, src_t cs);
    op_t o;
    o.a0 = a0; o.b0 = b0; o.a1 = a1; o.b1 = b1;
    o.dst = dst; o.cmode = cm; o.csrc = cs;
    return o;
  endfunction

  // Each op is a two-term dot product, saturated, optionally combined with a
  // third value. Single products use a zero second term.
  function automatic op_t op_decode(pc_t pc);
    op_t o;
    o = mk(SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, CM_NONE, SRC_ZERO);
    case (pc)
      5'd0:  o = mk(SRC_H0, SRC_X0, SRC_H1, SRC_X1, SRC_Y, CM_SUB, SRC_Z);
      5'd1:  o = mk(SRC_P00, SRC_H0, SRC_P01, SRC_H1, SRC_T0, CM_NONE, SRC_ZERO);
      5'd2:  o = mk(SRC_P10, SRC_H0, SRC_P11, SRC_H1, SRC_T1, CM_NONE, SRC_ZERO);
      5'd3:  o = mk(SRC_H0, SRC_T0, SRC_H1, SRC_T1, SRC_S, CM_ADD, SRC_RN);
      5'd4:  o = mk(SRC_H0, SRC_P00, SRC_H1, SRC_P10, SRC_R0, CM_NONE, SRC_ZERO);
      5'd5:  o = mk(SRC_H0, SRC_P01, SRC_H1, SRC_P11, SRC_R1, CM_NONE, SRC_ZERO);
      5'd6:  o = mk(SRC_K0, SRC_Y, SRC_ZERO, SRC_ZERO, SRC_X0, CM_ADD, SRC_X0);
      5'd7:  o = mk(SRC_K1, SRC_Y, SRC_ZERO, SRC_ZERO, SRC_X1, CM_ADD, SRC_X1);
      5'd8:  o = mk(SRC_K0, SRC_R0, SRC_ZERO, SRC_ZERO, SRC_P00, CM_SUB, SRC_P00);
      5'd9:  o = mk(SRC_K0, SRC_R1, SRC_ZERO, SRC_ZERO, SRC_P01, CM_SUB, SRC_P01);
      5'd10: o = mk(SRC_K1, SRC_R0, SRC_ZERO, SRC_ZERO, SRC_P10, CM_SUB, SRC_P10);
      5'd11: o = mk(SRC_K1, SRC_R1, SRC_ZERO, SRC_ZERO, SRC_P11, CM_SUB, SRC_P11);
      5'd12: o = mk(SRC_F00, SRC_X0, SRC_F01, SRC_X1, SRC_A0, CM_NONE, SRC_ZERO);
      5'd13: o = mk(SRC_F10, SRC_X0, SRC_F11, SRC_X1, SRC_A1, CM_NONE, SRC_ZERO);
      5'd14: o = mk(SRC_F00, SRC_P00, SRC_F01, SRC_P10, SRC_M00, CM_NONE, SRC_ZERO);
      5'd15: o = mk(SRC_F00, SRC_P01, SRC_F01, SRC_P11, SRC_M01, CM_NONE, SRC_ZERO);
      5'd16: o = mk(SRC_F10, SRC_P00, SRC_F11, SRC_P10, SRC_M10, CM_NONE, SRC_ZERO);
      5'd17: o = mk(SRC_F10, SRC_P01, SRC_F11, SRC_P11, SRC_M11, CM_NONE, SRC_ZERO);
      5'd18: o = mk(SRC_M00, SRC_F00, SRC_M01, SRC_F01, SRC_P00, CM_NONE, SRC_ZERO);
      5'd19: o = mk(SRC_M00, SRC_F10, SRC_M01, SRC_F11, SRC_P01, CM_NONE, SRC_ZERO);
      5'd20: o = mk(SRC_M10, SRC_F00, SRC_M11, SRC_F01, SRC_P10, CM_NONE, SRC_ZERO);
      5'd21: o = mk(SRC_M10, SRC_F10, SRC_M11, SRC_F11, SRC_P11, CM_NONE, SRC_ZERO);
      default: ;
    endcase
    return o;
  endfunction

endpackage

// ----- hw/rtl/kfcv_mac.sv -----
// Shared multiply, accumulate and saturate unit of the two-state filter.
// Depends on kfcv_pkg for the control struct and mode codes.
module kfcv_mac import kfcv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  input  logic signed [DATA_W-1:0] cval,
  input  cmode_t                   cmode,
  output logic signed [DATA_W-1:0] res,
  output logic                     clamp
);

  localparam logic signed [63:0] MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] MIN64 = -64'sd2147483648;

  logic signed [63:0]     prod_r;
  logic signed [63:0]     acc_r;
  logic signed [63:0]     sh;
  logic signed [DATA_W-1:0] r1;
  logic                   c1;
  logic signed [DATA_W:0] sum;
  logic                   c2;

  // Arithmetic right shift rounds toward minus infinity.
  assign sh = prod_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= 64'(a * b);
    end
    if (ctl.acc_load) begin
      acc_r <= sh;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + sh;
    end
  end

  always_comb begin
    c1 = 1'b0;
    if (acc_r > MAX64) begin
      r1 = 32'sh7FFF_FFFF;
      c1 = 1'b1;
    end else if (acc_r < MIN64) begin
      r1 = 32'sh8000_0000;
      c1 = 1'b1;
    end else begin
      r1 = acc_r[DATA_W-1:0];
    end

    if (cmode == CM_SUB) begin
      sum = {cval[DATA_W-1], cval} - {r1[DATA_W-1], r1};
    end else begin
      sum = {cval[DATA_W-1], cval} + {r1[DATA_W-1], r1};
    end

    c2 = 1'b0;
    res = r1;
    if (cmode != CM_NONE) begin
      if (sum[DATA_W] != sum[DATA_W-1]) begin
        c2 = 1'b1;
        res = sum[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        res = sum[DATA_W-1:0];
      end
    end
    clamp = c1 | c2;
  end

endmodule

// ----- hw/rtl/kfcv_div.sv -----
// Bit-serial restoring divider for the gain terms: (num * 2^F) / den, truncated, clamped.
// Depends on kfcv_pkg for the result struct.
module kfcv_div import kfcv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output div_res_t                 res
);

  localparam int NW  = DATA_W + FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM = NW'(64'h8000_0000);

  logic [NW-1:0]     num_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] den_r;
  logic [CW-1:0]     cnt_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W-1:0] mag;
  logic [DATA_W:0]   trial;
  logic              fits;

  assign mag   = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {mag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? DATA_W'(trial - {1'b0, den_r}) : trial[DATA_W-1:0];
      num_r <= {num_r[NW-2:0], fits};
    end
  end

  always_comb begin
    res.done = done_r;
    if (neg_r) begin
      res.clamp = num_r > LIM;
      res.quot  = res.clamp ? 32'h8000_0000 : DATA_W'(-num_r);
    end else begin
      res.clamp = num_r >= LIM;
      res.quot  = res.clamp ? 32'h7FFF_FFFF : num_r[DATA_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/kalman_filter_two_state_scalar_core.sv -----
// Two-state (position, velocity) constant-velocity Kalman filter on signed
// fixed-point values with FRAC_BITS fraction bits. Each input word carries one
// measurement and a restart flag; each produces one output word with the
// predicted state, the two diagonal covariance terms and two flags. One shared
// 32x32 multiplier with a 64-bit accumulator runs a fixed program of 22
// dot-product steps, and one bit-serial divider computes the two gain terms.
// An item runs the first four steps, the two gains, the remaining 18 steps
// and the finish state; the next word is then accepted in the idle state.
// When the update is skipped only 14 steps run. The input is ready only while
// the sequencer is idle. The output register holds a finished word until it
// is taken, and a new input word is accepted meanwhile. Configuration is
// written through a plain write port and should be written only while the
// block is idle.
// Depends on kfcv_pkg, kfcv_mac and kfcv_div.
module kalman_filter_two_state_scalar_core import kfcv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] measurement
  input  logic [0:0]   in_tuser,   // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] position_est, [63:32] velocity_est, [95:64] position_var,
  // [127:96] velocity_var
  output logic [127:0] out_tdata,
  output logic [1:0]   out_tuser,  // [0] update_skipped, [1] saturated
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  // Reset diagonal of 100.0, clamped when it does not fit 32 bits.
  localparam longint DIAG_L = longint'(RST_DIAG_UNITS) << FRAC_BITS;
  localparam logic [31:0] RST_DIAG = (DIAG_L > 64'sd2147483647) ?
                                     32'h7FFF_FFFF : 32'(DIAG_L);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_DIV0 = 3'd2;
  localparam logic [2:0] ST_DIV1 = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Configuration registers.
  logic signed [31:0] f00_r, f01_r, f10_r, f11_r, h0_r, h1_r;
  logic [30:0]        rn_r, iv_r;

  // Filter state and working values.
  logic signed [31:0] x0_r, x1_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] z_r, y_r, t0_r, t1_r, s_r, k0_r, k1_r, r0_r, r1_r;
  logic signed [31:0] m00_r, m01_r, m10_r, m11_r, a0_r, a1_r;

  logic [2:0]  state_r;
  pc_t         pc_r;
  logic [1:0]  ph_r;
  logic        skip_r;
  logic        clamp_r;
  logic        out_valid_r;
  logic [127:0] out_data_r;
  logic [1:0]  out_user_r;

  op_t                op;
  mac_ctl_t           mac_ctl;
  logic signed [31:0] opa, opb, cval, mac_res;
  logic               mac_clamp;
  logic               div_start;
  logic signed [31:0] div_num, div_den;
  div_res_t           div_res;
  logic               wb;
  logic               in_acc;

  function automatic logic signed [31:0] pick(
    src_t code,
    logic signed [31:0] x0, logic signed [31:0] x1,
    logic signed [31:0] p00, logic signed [31:0] p01,
    logic signed [31:0] p10, logic signed [31:0] p11,
    logic signed [31:0] y, logic signed [31:0] t0, logic signed [31:0] t1,
    logic signed [31:0] s, logic signed [31:0] k0, logic signed [31:0] k1,
    logic signed [31:0] r0, logic signed [31:0] r1,
    logic signed [31:0] m00, logic signed [31:0] m01,
    logic signed [31:0] m10, logic signed [31:0] m11,
    logic signed [31:0] a0, logic signed [31:0] a1,
    logic signed [31:0] f00, logic signed [31:0] f01,
    logic signed [31:0] f10, logic signed [31:0] f11,
    logic signed [31:0] h0, logic signed [31:0] h1,
    logic signed [31:0] rn, logic signed [31:0] z);
    logic signed [31:0] v;
    case (code)
      SRC_X0:  v = x0;
      SRC_X1:  v = x1;
      SRC_P00: v = p00;
      SRC_P01: v = p01;
      SRC_P10: v = p10;
      SRC_P11: v = p11;
      SRC_Y:   v = y;
      SRC_T0:  v = t0;
      SRC_T1:  v = t1;
      SRC_S:   v = s;
      SRC_K0:  v = k0;
      SRC_K1:  v = k1;
      SRC_R0:  v = r0;
      SRC_R1:  v = r1;
      SRC_M00: v = m00;
      SRC_M01: v = m01;
      SRC_M10: v = m10;
      SRC_M11: v = m11;
      SRC_A0:  v = a0;
      SRC_A1:  v = a1;
      SRC_F00: v = f00;
      SRC_F01: v = f01;
      SRC_F10: v = f10;
      SRC_F11: v = f11;
      SRC_H0:  v = h0;
      SRC_H1:  v = h1;
      SRC_RN:  v = rn;
      SRC_Z:   v = z;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign op        = op_decode(pc_r);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wb        = (state_r == ST_RUN) && (ph_r == 2'd3);

  // The first phase multiplies the first term; the second phase the second.
  always_comb begin
    opa = pick((ph_r == 2'd0) ? op.a0 : op.a1,
               x0_r, x1_r, p00_r, p01_r, p10_r, p11_r, y_r, t0_r, t1_r, s_r,
               k0_r, k1_r, r0_r, r1_r, m00_r, m01_r, m10_r, m11_r, a0_r, a1_r,
               f00_r, f01_r, f10_r, f11_r, h0_r, h1_r, {1'b0, rn_r}, z_r);
    opb = pick((ph_r == 2'd0) ? op.b0 : op.b1,
               x0_r, x1_r, p00_r, p01_r, p10_r, p11_r, y_r, t0_r, t1_r, s_r,
               k0_r, k1_r, r0_r, r1_r, m00_r, m01_r, m10_r, m11_r, a0_r, a1_r,
               f00_r, f01_r, f10_r, f11_r, h0_r, h1_r, {1'b0, rn_r}, z_r);
    cval = pick(op.csrc,
               x0_r, x1_r, p00_r, p01_r, p10_r, p11_r, y_r, t0_r, t1_r, s_r,
               k0_r, k1_r, r0_r, r1_r, m00_r, m01_r, m10_r, m11_r, a0_r, a1_r,
               f00_r, f01_r, f10_r, f11_r, h0_r, h1_r, {1'b0, rn_r}, z_r);
  end

  always_comb begin
    mac_ctl.mul_en   = (state_r == ST_RUN) && (ph_r == 2'd0 || ph_r == 2'd1);
    mac_ctl.acc_load = (state_r == ST_RUN) && (ph_r == 2'd1);
    mac_ctl.acc_add  = (state_r == ST_RUN) && (ph_r == 2'd2);
  end

  kfcv_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .a     (opa),
    .b     (opb),
    .cval  (cval),
    .cmode (op.cmode),
    .res   (mac_res),
    .clamp (mac_clamp)
  );

  // The first gain starts straight from the innovation variance as it is
  // written back; the second starts when the first is done.
  always_comb begin
    div_start = 1'b0;
    div_num   = t0_r;
    div_den   = mac_res;
    if (wb && pc_r == OP_S && mac_res > 32'sd0) begin
      div_start = 1'b1;
    end else if (state_r == ST_DIV0 && div_res.done) begin
      div_start = 1'b1;
      div_num   = t1_r;
      div_den   = s_r;
    end
  end

  kfcv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  // Configuration port; writes beyond the list do not exist with a 3-bit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f00_r <= 32'sd65536;
      f01_r <= 32'sd65536;
      f10_r <= 32'sd0;
      f11_r <= 32'sd65536;
      h0_r  <= 32'sd65536;
      h1_r  <= 32'sd0;
      rn_r  <= 31'd65536;
      iv_r  <= 31'd6553600;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_F00: f00_r <= cfg_wdata;
        REG_F01: f01_r <= cfg_wdata;
        REG_F10: f10_r <= cfg_wdata;
        REG_F11: f11_r <= cfg_wdata;
        REG_H0:  h0_r  <= cfg_wdata;
        REG_H1:  h1_r  <= cfg_wdata;
        REG_RN:  rn_r  <= cfg_wdata[30:0];
        REG_IV:  iv_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      ph_r        <= '0;
      skip_r      <= 1'b0;
      clamp_r     <= 1'b0;
      out_valid_r <= 1'b0;
      x0_r        <= '0;
      x1_r        <= '0;
      p00_r       <= RST_DIAG;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= RST_DIAG;
    end else begin
      // In the finish state a taken word is replaced by the new one below.
      if (out_valid_r && out_tready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            z_r     <= in_tdata;
            pc_r    <= '0;
            ph_r    <= '0;
            skip_r  <= 1'b0;
            clamp_r <= 1'b0;
            state_r <= ST_RUN;
            if (in_tuser[0]) begin
              x0_r  <= '0;
              x1_r  <= '0;
              p00_r <= {1'b0, iv_r};
              p01_r <= '0;
              p10_r <= '0;
              p11_r <= {1'b0, iv_r};
            end
          end
        end
        ST_RUN: begin
          ph_r <= ph_r + 2'd1;
          if (wb) begin
            clamp_r <= clamp_r | mac_clamp;
            case (op.dst)
              SRC_X0:  x0_r  <= mac_res;
              SRC_X1:  x1_r  <= mac_res;
              SRC_P00: p00_r <= mac_res;
              SRC_P01: p01_r <= mac_res;
              SRC_P10: p10_r <= mac_res;
              SRC_P11: p11_r <= mac_res;
              SRC_Y:   y_r   <= mac_res;
              SRC_T0:  t0_r  <= mac_res;
              SRC_T1:  t1_r  <= mac_res;
              SRC_S:   s_r   <= mac_res;
              SRC_R0:  r0_r  <= mac_res;
              SRC_R1:  r1_r  <= mac_res;
              SRC_M00: m00_r <= mac_res;
              SRC_M01: m01_r <= mac_res;
              SRC_M10: m10_r <= mac_res;
              SRC_M11: m11_r <= mac_res;
              SRC_A0:  a0_r  <= mac_res;
              SRC_A1:  a1_r  <= mac_res;
              default: ;
            endcase
            if (pc_r == OP_S) begin
              if (mac_res > 32'sd0) begin
                state_r <= ST_DIV0;
              end else begin
                // Non-positive innovation variance: keep the prior and predict.
                skip_r <= 1'b1;
                pc_r   <= OP_A0;
              end
            end else if (pc_r == OP_LAST) begin
              state_r <= ST_FIN;
            end else begin
              pc_r <= pc_r + 5'd1;
            end
          end
        end
        ST_DIV0: begin
          if (div_res.done) begin
            k0_r    <= div_res.quot;
            clamp_r <= clamp_r | div_res.clamp;
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_res.done) begin
            k1_r    <= div_res.quot;
            clamp_r <= clamp_r | div_res.clamp;
            pc_r    <= OP_R0;
            ph_r    <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            x0_r        <= a0_r;
            x1_r        <= a1_r;
            out_valid_r <= 1'b1;
            out_data_r  <= {p11_r, p00_r, a1_r, a0_r};
            out_user_r  <= {clamp_r, skip_r};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hw/rtl/kfcv_chk.sv -----
// Port-level checker for the two-state filter core, bound to the top level.
// Depends on assert_macros.svh and kalman_filter_two_state_scalar_core.
`include "assert_macros.svh"

module kfcv_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  `KF_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")
  `KF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input still ready after a word was taken")
  `KF_ASSERT_NXT(a_no_instant_result, clk, rst_n, in_tvalid && in_tready, !$rose(out_tvalid), "result appeared one cycle after accept")

endmodule

bind kalman_filter_two_state_scalar_core kfcv_chk u_kfcv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
